// ===== rtl/assert_macros.svh =====
// Assertion macros used by message_duplicate_filter.
// No dependencies; include guard below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define MDF_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define MDF_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/mdf_pkg.sv =====
// Package for the message duplicate filter: beat types, constants, hash step.
// No dependencies.
package mdf_pkg;

  localparam int HASH_W         = 32;
  localparam int RING_DEPTH_DEF = 16;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } mdf_in_t;

  typedef struct packed {
    logic              duplicate;
    logic [HASH_W-1:0] msg_hash;
  } mdf_out_t;

  // request from the compare stage to the cell row
  typedef struct packed {
    logic              insert;
    logic [HASH_W-1:0] hash;
  } ring_req_t;

  // djb2 step: h * 33 + b, mod 2^32
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    hash_step = (h << 5) + h + {{(HASH_W-8){1'b0}}, b};
  endfunction

endpackage

// ===== rtl/mdf_cell.sv =====
// One entry of the seen-hash row: holds a hash, compares it against the probe,
// and takes its neighbor's entry on insert. Depends on mdf_pkg.
module mdf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [mdf_pkg::HASH_W-1:0] din,
  input  logic [mdf_pkg::HASH_W-1:0] probe,
  output logic [mdf_pkg::HASH_W-1:0] entry,
  output logic                       hit
);
  import mdf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign hit = (entry == probe);

endmodule

// ===== rtl/mdf_ring.sv =====
// Row of mdf_cell entries acting as the ring of recent hashes.
// Depends on mdf_pkg and mdf_cell.
module mdf_ring #(
  parameter int DEPTH = mdf_pkg::RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mdf_pkg::ring_req_t req,
  output logic               hit
);
  import mdf_pkg::*;

  logic [HASH_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]  hit_vec;

  // Insert shifts the row by one: cell 0 takes the new hash and the oldest
  // falls off the far end, same set as overwriting at a wrapping pointer.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HASH_W-1:0] din;
    if (i == 0) begin : g_head
      assign din = req.hash;
    end else begin : g_link
      assign din = entry[i-1];
    end
    mdf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (req.insert),
      .din   (din),
      .probe (req.hash),
      .entry (entry[i]),
      .hit   (hit_vec[i])
    );
  end

  assign hit = |hit_vec;

endmodule

// ===== rtl/message_duplicate_filter.sv =====
// Message duplicate filter: takes one message byte per beat, folds it into a
// djb2 hash (seed 5381, times 33 plus byte), and on the beat marked last gives
// one result with the hash and a flag saying whether it is among the last
// RING_DEPTH new hashes (entries reset to zero, so a zero hash matches). A new
// hash is recorded, displacing the oldest. Sustained rate is one byte per
// cycle unless a held result stalls input. The hash is registered in the
// compare stage, where every cell of the row checks it in parallel and the
// row shifts in the new entry in the same cycle, then in the result register.
// Depends on mdf_pkg, mdf_ring, mdf_cell and assert_macros.svh.
`include "assert_macros.svh"

module message_duplicate_filter #(
  parameter int RING_DEPTH = mdf_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_ready,
  input  mdf_pkg::mdf_in_t  msg,
  output logic              res_valid,
  input  logic              res_ready,
  output mdf_pkg::mdf_out_t res
);
  import mdf_pkg::*;

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] hash_next;
  logic              cmp_valid;
  logic [HASH_W-1:0] cmp_hash;
  logic              cmp_advance;
  logic              msg_fire;
  logic              ring_hit;
  ring_req_t         ring_req;

  assign cmp_advance = cmp_valid && (!res_valid || res_ready);
  assign msg_ready   = !cmp_valid || cmp_advance;
  assign msg_fire    = msg_valid && msg_ready;
  assign hash_next   = hash_step(running_hash, msg.data_byte);

  // hash accumulate; finished hash moves to the compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
      cmp_valid    <= 1'b0;
    end else begin
      if (msg_fire) begin
        running_hash <= msg.last ? HASH_SEED : hash_next;
      end
      if (msg_fire && msg.last) begin
        cmp_valid <= 1'b1;
      end else if (cmp_advance) begin
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_fire && msg.last) begin
      cmp_hash <= hash_next;
    end
  end

  assign ring_req.insert = cmp_advance && !ring_hit;
  assign ring_req.hash   = cmp_hash;

  mdf_ring #(.DEPTH(RING_DEPTH)) u_ring (
    .clk (clk),
    .rst (rst),
    .req (ring_req),
    .hit (ring_hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmp_advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_advance) begin
      res.duplicate <= ring_hit;
      res.msg_hash  <= cmp_hash;
    end
  end

  `MDF_ASSERT_CLK(a_seed_after_last, clk, rst, msg_fire && msg.last |=> running_hash == HASH_SEED, "hash not reseeded after last byte")
  `MDF_ASSERT_CLK(a_cmp_to_res, clk, rst, cmp_advance |=> res_valid && res.msg_hash == $past(cmp_hash), "compare result lost")
  `MDF_ASSERT_CLK(a_cmp_hold, clk, rst, cmp_valid && !cmp_advance |=> cmp_valid && $stable(cmp_hash), "stalled hash changed")

endmodule
